// ===== rtl/remc_pkg.sv =====
package remc_pkg;

    // APB configuration port
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    // Stream payload widths
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 24;

    // Register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_THRESHOLD   = 2'd0;
    localparam logic [1:0] REG_FIRST_STEP  = 2'd1;
    localparam logic [1:0] REG_SECOND_STEP = 2'd2;

    // Register reset values
    localparam logic [3:0] THRESHOLD_RST   = 4'd4;
    localparam logic [7:0] FIRST_STEP_RST  = 8'd1;
    localparam logic [7:0] SECOND_STEP_RST = 8'd5;

    // Menu state reset values
    localparam logic [7:0] FIRST_QTY_RST  = 8'd2;
    localparam logic [7:0] SECOND_QTY_RST = 8'd65;

    // Both phases high: the rest position of a detent
    localparam logic [1:0] PHASE_REST = 2'b11;

    // Detent codes, two bit signed
    localparam logic [1:0] DET_NONE = 2'b00;
    localparam logic [1:0] DET_CW   = 2'b01;
    localparam logic [1:0] DET_CCW  = 2'b11;

    // Accumulator saturation limits (9 bit working width)
    localparam logic signed [8:0] ACC_MAX = 9'sd127;
    localparam logic signed [8:0] ACC_MIN = -9'sd127;

    typedef struct packed {
        logic [3:0] threshold;
        logic [7:0] first_step;
        logic [7:0] second_step;
    } t_cfg;

    typedef struct packed {
        logic       kind;
        logic [1:0] phase;   // {a, b}
    } t_item;

    // Quadrature transition table, index {previous AB, current AB}
    function automatic logic signed [1:0] quad_delta(input logic [3:0] idx);
        logic signed [1:0] d;
        case (idx)
            4'd1, 4'd7, 4'd8, 4'd14:  d = -2'sd1;
            4'd2, 4'd4, 4'd11, 4'd13: d = 2'sd1;
            default:                  d = 2'sd0;
        endcase
        return d;
    endfunction

endpackage

// ===== rtl/remc_cfg.sv =====
module remc_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [remc_pkg::ADDR_W-1:0]   paddr,
    input  logic [remc_pkg::DATA_W-1:0]   pwdata,
    output logic [remc_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output remc_pkg::t_cfg                o_cfg
);

    remc_pkg::t_cfg r_cfg;
    logic [1:0]     reg_idx;
    logic           wr_en;

    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    // Register writes on the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold   <= remc_pkg::THRESHOLD_RST;
            r_cfg.first_step  <= remc_pkg::FIRST_STEP_RST;
            r_cfg.second_step <= remc_pkg::SECOND_STEP_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                remc_pkg::REG_THRESHOLD:   r_cfg.threshold   <= pwdata[3:0];
                remc_pkg::REG_FIRST_STEP:  r_cfg.first_step  <= pwdata[7:0];
                remc_pkg::REG_SECOND_STEP: r_cfg.second_step <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        unique case (reg_idx)
            remc_pkg::REG_THRESHOLD:   prdata = {28'd0, r_cfg.threshold};
            remc_pkg::REG_FIRST_STEP:  prdata = {24'd0, r_cfg.first_step};
            remc_pkg::REG_SECOND_STEP: prdata = {24'd0, r_cfg.second_step};
            default:                   prdata = '0;
        endcase
    end

endmodule

// ===== rtl/remc_quad.sv =====
module remc_quad (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  remc_pkg::t_item   i_item,
    input  logic [3:0]        i_threshold,
    output logic [1:0]        o_detent
);

    logic [1:0]        r_last_phase;
    logic signed [7:0] r_accum;
    logic signed [7:0] n_accum;

    logic signed [1:0] delta;
    logic signed [8:0] sum;
    logic signed [8:0] sat;
    logic [3:0]        thr;
    logic signed [8:0] thr_pos;
    logic signed [8:0] thr_neg;
    logic              at_rest;

    // Table step, add and saturate
    always_comb begin
        delta   = remc_pkg::quad_delta({r_last_phase, i_item.phase});
        sum     = {r_accum[7], r_accum} + {{7{delta[1]}}, delta};
        if (sum > remc_pkg::ACC_MAX) begin
            sat = remc_pkg::ACC_MAX;
        end else if (sum < remc_pkg::ACC_MIN) begin
            sat = remc_pkg::ACC_MIN;
        end else begin
            sat = sum;
        end
        thr     = (i_threshold == 4'd0) ? 4'd1 : i_threshold;
        thr_pos = $signed({5'd0, thr});
        thr_neg = -thr_pos;
        at_rest = (i_item.phase == remc_pkg::PHASE_REST);
    end

    // Detent decision; a button press never reports one
    always_comb begin
        o_detent = remc_pkg::DET_NONE;
        n_accum  = sat[7:0];
        if (!i_item.kind && at_rest && (sat >= thr_pos)) begin
            o_detent = remc_pkg::DET_CW;
            n_accum  = '0;
        end else if (!i_item.kind && at_rest && (sat <= thr_neg)) begin
            o_detent = remc_pkg::DET_CCW;
            n_accum  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_phase <= remc_pkg::PHASE_REST;
            r_accum      <= '0;
        end else if (i_fire && !i_item.kind) begin
            r_last_phase <= i_item.phase;
            r_accum      <= n_accum;
        end
    end

`ifndef SYNTH
    a_no_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_accum != -8'sd128)
        else $error("accumulator left its saturation range");

    a_detent_at_rest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && (o_detent != remc_pkg::DET_NONE) |-> (i_item.phase == remc_pkg::PHASE_REST))
        else $error("detent reported away from rest phase");

    a_clear_on_detent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && (o_detent != remc_pkg::DET_NONE) |=> (r_accum == 8'sd0))
        else $error("accumulator not cleared after detent");
`endif

endmodule

// ===== rtl/remc_menu.sv =====
module remc_menu (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  logic              i_kind,
    input  logic [1:0]        i_detent,
    input  remc_pkg::t_cfg    i_cfg,
    output logic              o_row,
    output logic              o_editing,
    output logic [7:0]        o_first_amount,
    output logic [7:0]        o_second_amount,
    output logic [1:0]        o_marks,
    output logic [1:0]        o_detent
);

    logic       r_sel_row;
    logic       r_edit;
    logic [7:0] r_first_qty;
    logic [7:0] r_second_qty;
    logic [1:0] r_marks;
    logic [1:0] r_detent;

    logic       n_sel_row;
    logic       n_edit;
    logic [7:0] n_first_qty;
    logic [7:0] n_second_qty;
    logic [1:0] n_marks;

    logic [1:0] row_bit;
    logic       cw;
    logic       ccw;

    assign row_bit = r_sel_row ? 2'b10 : 2'b01;
    assign cw      = (i_detent == remc_pkg::DET_CW);
    assign ccw     = (i_detent == remc_pkg::DET_CCW);

    // Next menu state for one item
    always_comb begin
        n_sel_row    = r_sel_row;
        n_edit       = r_edit;
        n_first_qty  = r_first_qty;
        n_second_qty = r_second_qty;
        n_marks      = r_marks;
        if (i_kind) begin
            // button: enter edit and clear mark, or toggle mark and leave
            if (!r_edit) begin
                n_edit  = 1'b1;
                n_marks = r_marks & ~row_bit;
            end else begin
                n_edit  = 1'b0;
                n_marks = r_marks ^ row_bit;
            end
        end else if (cw || ccw) begin
            if (!r_edit) begin
                n_sel_row = cw;
            end else if (!r_sel_row) begin
                n_first_qty = cw ? r_first_qty + i_cfg.first_step
                                 : r_first_qty - i_cfg.first_step;
            end else begin
                n_second_qty = cw ? r_second_qty + i_cfg.second_step
                                  : r_second_qty - i_cfg.second_step;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel_row    <= 1'b0;
            r_edit       <= 1'b0;
            r_first_qty  <= remc_pkg::FIRST_QTY_RST;
            r_second_qty <= remc_pkg::SECOND_QTY_RST;
            r_marks      <= 2'b00;
            r_detent     <= remc_pkg::DET_NONE;
        end else if (i_fire) begin
            r_sel_row    <= n_sel_row;
            r_edit       <= n_edit;
            r_first_qty  <= n_first_qty;
            r_second_qty <= n_second_qty;
            r_marks      <= n_marks;
            r_detent     <= i_kind ? remc_pkg::DET_NONE : i_detent;
        end
    end

    // State registers double as the result payload
    assign o_row           = r_sel_row;
    assign o_editing       = r_edit;
    assign o_first_amount  = r_first_qty;
    assign o_second_amount = r_second_qty;
    assign o_marks         = r_marks;
    assign o_detent        = r_detent;

endmodule

// ===== rtl/rotary_encoder_menu_control_core.sv =====
// Channel   Direction  Transfer payload
// s_*       in         tuser: kind; tdata: enc_a, enc_b
// m_*       out        tdata: row, editing, first_amount, second_amount, row_marks, detent
// APB       in/out     detent_threshold @0x0, first_step @0x4, second_step @0x8
//
// One item per cycle sustained while m_tready stays high; each input transfer passes
// through an input register, then table lookup, saturating add and menu update
// into the state/result registers.
// Synchronous active-low reset returns the menu, accumulator and registers to
// their defaults. A stalled result holds the pipeline; s_tready then follows
// m_tready combinationally so no bubble is lost.
module rotary_encoder_menu_control_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input stream
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [remc_pkg::IN_TDATA_W-1:0]     i_s_tdata,   // [0] enc_a, [1] enc_b
    input  logic                                i_s_tuser,   // [0] kind
    // result stream
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // [0] row, [1] editing, [9:2] first_amount, [17:10] second_amount,
    // [19:18] row_marks, [21:20] detent
    output logic [remc_pkg::OUT_TDATA_W-1:0]    o_m_tdata,
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [remc_pkg::ADDR_W-1:0]         paddr,
    input  logic [remc_pkg::DATA_W-1:0]         pwdata,
    output logic [remc_pkg::DATA_W-1:0]         prdata,
    output logic                                pready
);

    remc_pkg::t_cfg  cfg;
    remc_pkg::t_item r_in;
    logic            r_in_valid;
    logic            r_out_valid;
    logic            fire;
    logic            s_xfer;
    logic [1:0]      detent;

    logic            row;
    logic            editing;
    logic [7:0]      first_amount;
    logic [7:0]      second_amount;
    logic [1:0]      marks;
    logic [1:0]      det_out;

    // Handshake: stage advances when the result slot is free or draining
    assign fire       = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || fire;
    assign s_xfer     = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid <= s_xfer || (r_in_valid && !fire);
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Input payload register
    always_ff @(posedge i_clk) begin
        if (s_xfer) begin
            r_in.kind  <= i_s_tuser;
            r_in.phase <= {i_s_tdata[0], i_s_tdata[1]};
        end
    end

    remc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    remc_quad u_quad (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_item      (r_in),
        .i_threshold (cfg.threshold),
        .o_detent    (detent)
    );

    remc_menu u_menu (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_fire          (fire),
        .i_kind          (r_in.kind),
        .i_detent        (detent),
        .i_cfg           (cfg),
        .o_row           (row),
        .o_editing       (editing),
        .o_first_amount  (first_amount),
        .o_second_amount (second_amount),
        .o_marks         (marks),
        .o_detent        (det_out)
    );

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {2'b00, det_out, marks, second_amount, first_amount, editing, row};

endmodule
